FILE: rtl/sdsg_pkg.sv
package sdsg_pkg;

  localparam int SPACING_W = 10;
  localparam int COORD_W   = 16;
  localparam int CMD_W     = 2;
  localparam int CARRY_W   = 24;
  localparam int DELTA_W   = COORD_W + 1;
  localparam int SQ_W      = 2 * DELTA_W;
  localparam int RAD_W     = 50;
  localparam int LEN_W     = RAD_W / 2;
  localparam int SP_W      = SPACING_W + 8;
  localparam int DIST_W    = LEN_W + 1;
  localparam int NQ_W      = DIST_W - 8;
  localparam int T_W       = 26;
  localparam int PROD_W    = DELTA_W + T_W;
  localparam int DVD_W     = RAD_W;
  localparam int OFF_W     = 36;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_DABS_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] ADDR_DAB_SPACING = 3'd0;

  typedef struct packed {
    logic delta;
    logic square;
    logic sqrt_start;
    logic divn_start;
    logic divn_save;
    logic dab_init;
    logic axis_y;
    logic mul;
    logic divo_start;
    logic divo_save;
    logic off_clear;
    logic pos;
    logic out_load_press;
    logic out_load_dab;
    logic dab_next;
    logic press;
    logic release_drag;
    logic commit;
  } sdsg_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] ev_cmd;
    logic             left;
    logic             vis;
    logic             drag;
    logic             sqrt_busy;
    logic             div_busy;
    logic             n_zero;
    logic             len_zero;
    logic             last;
    logic             out_free;
  } sdsg_stat_t;

  // q8 to whole pixels, half away from zero, wrapped to 16 bits
  function automatic logic [COORD_W-1:0] round_q8(input logic signed [OFF_W-1:0] q);
    logic [OFF_W-1:0] mag;
    logic [OFF_W-1:0] r;
    if (!q[OFF_W-1]) begin
      r = (OFF_W'(q) + OFF_W'(128)) >> 8;
    end else begin
      mag = OFF_W'(-q);
      r = (mag + OFF_W'(128)) >> 8;
      r = OFF_W'(-r);
    end
    return r[COORD_W-1:0];
  endfunction

endpackage

FILE: rtl/sdsg_div.sv
module sdsg_div #(
  parameter int DVD_W = sdsg_pkg::DVD_W,
  parameter int DVS_W = sdsg_pkg::LEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DVS_W:0]   sh;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge = sh >= {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? DVS_W'(sh - {1'b0, dvs_r}) : sh[DVS_W-1:0];
      dvd_nxt  = {dvd_r[DVD_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/sdsg_sqrt.sv
module sdsg_sqrt #(
  parameter int RAD_W = sdsg_pkg::RAD_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [RAD_W-1:0]     radicand,
  output logic                 busy,
  output logic [RAD_W/2-1:0]   root
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [REM_W-1:0]  rem2;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // two radicand bits in, one root bit out per cycle
  assign rem2  = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = rem2 >= trial;

  always_comb begin
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt  = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? rem2 - trial : rem2;
      root_nxt = {root_r[ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      root_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      root_r <= root_nxt;
    end
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

FILE: rtl/sdsg_dp.sv
module sdsg_dp #(
  parameter int MAX_DABS = sdsg_pkg::MAX_DABS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_accept,
  input  logic [sdsg_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [sdsg_pkg::COORD_W-1:0]  in_pointer_x,
  input  logic signed [sdsg_pkg::COORD_W-1:0]  in_pointer_y,
  input  logic                                 in_left_button,
  input  logic                                 in_layer_visible,
  input  logic [sdsg_pkg::SPACING_W-1:0]       dab_spacing,
  input  sdsg_pkg::sdsg_cmd_t                  cmd,
  output sdsg_pkg::sdsg_stat_t                 stat,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [sdsg_pkg::COORD_W-1:0]  out_dab_x,
  output logic signed [sdsg_pkg::COORD_W-1:0]  out_dab_y,
  output logic                                 out_last_dab,
  output logic                                 out_truncated
);

  localparam int CW  = sdsg_pkg::COORD_W;
  localparam int KW  = $clog2(MAX_DABS + 1);
  localparam int DW  = sdsg_pkg::DELTA_W;
  localparam int TW  = sdsg_pkg::T_W;
  localparam int PW  = sdsg_pkg::PROD_W;
  localparam int OW  = sdsg_pkg::OFF_W;
  localparam int LW  = sdsg_pkg::LEN_W;
  localparam int SW  = sdsg_pkg::SP_W;
  localparam int NW  = sdsg_pkg::NQ_W;
  localparam int QW  = sdsg_pkg::DVD_W;

  // latched event
  logic [sdsg_pkg::CMD_W-1:0] ev_cmd_r;
  logic signed [CW-1:0]       px_r, py_r;
  logic                       left_r, vis_r;

  // stroke state
  logic                              drag_r;
  logic signed [CW-1:0]              anchor_x_r, anchor_y_r;
  logic [sdsg_pkg::CARRY_W-1:0]      carried_r;

  // working registers
  logic signed [DW-1:0]         dx_r, dy_r;
  logic [sdsg_pkg::SQ_W-1:0]    dxsq_r, dysq_r;
  logic [NW-1:0]                n_r;
  logic [SW-1:0]                newc_r;
  logic signed [TW-1:0]         t_r;
  logic [KW-1:0]                k_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [OW-1:0]         offx_r, offy_r;
  logic [CW-1:0]                posx_r, posy_r;

  logic                 out_valid_r;
  logic [CW-1:0]        out_x_r, out_y_r;
  logic                 out_last_r, out_trunc_r;

  logic [SW-1:0]                sp;
  logic [sdsg_pkg::SPACING_W-1:0] sp_px;
  logic [LW-1:0]                len;
  logic                         sqrt_busy, div_busy;
  logic [QW-1:0]                div_q;
  logic [LW-1:0]                div_rem;
  logic [QW-1:0]                dvd;
  logic [LW-1:0]                dvs;
  logic [PW-1:0]                prod_abs;
  logic [sdsg_pkg::DIST_W-1:0]  dist_sum;
  logic [sdsg_pkg::RAD_W-1:0]   rad;
  logic [KW-1:0]                m;
  logic                         over;
  logic signed [OW-1:0]         quo_s;
  logic signed [OW-1:0]         off_new;
  logic signed [OW-1:0]         ax_q8, ay_q8;
  logic                         out_free;

  assign sp_px = (dab_spacing == '0) ? sdsg_pkg::SPACING_W'(1) : dab_spacing;
  assign sp    = {sp_px, 8'h00};
  assign dist_sum = sdsg_pkg::DIST_W'(carried_r) + sdsg_pkg::DIST_W'(len);
  assign prod_abs = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);

  assign dvd = cmd.divo_start ? {prod_abs[PW-2:0], 8'h00} : QW'(dist_sum);
  assign dvs = cmd.divo_start ? len : LW'(sp);

  // squared length scaled by 2^16 so the root comes out in q8
  assign rad = {sdsg_pkg::SQ_W'(dxsq_r + dysq_r), 16'h0000};

  sdsg_sqrt #(.RAD_W(sdsg_pkg::RAD_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (rad),
    .busy     (sqrt_busy),
    .root     (len)
  );

  sdsg_div #(.DVD_W(QW), .DVS_W(LW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.divn_start | cmd.divo_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_rem)
  );

  assign over  = n_r > NW'(MAX_DABS);
  assign m     = (n_r >= NW'(MAX_DABS)) ? KW'(MAX_DABS) : n_r[KW-1:0];
  assign quo_s = {1'b0, div_q[OW-2:0]};
  assign off_new = prod_r[PW-1] ? -quo_s : quo_s;
  assign ax_q8 = {OW'(anchor_x_r)} <<< 8;
  assign ay_q8 = {OW'(anchor_y_r)} <<< 8;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r      <= 1'b0;
      anchor_x_r  <= '0;
      anchor_y_r  <= '0;
      carried_r   <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (cmd.press) begin
        drag_r     <= 1'b1;
        anchor_x_r <= px_r;
        anchor_y_r <= py_r;
        carried_r  <= '0;
      end
      if (cmd.release_drag) begin
        drag_r <= 1'b0;
      end
      if (cmd.commit) begin
        carried_r  <= sdsg_pkg::CARRY_W'(newc_r);
        anchor_x_r <= px_r;
        anchor_y_r <= py_r;
      end
      if (cmd.dab_init) begin
        k_r <= KW'(1);
      end else if (cmd.dab_next) begin
        k_r <= k_r + KW'(1);
      end
      if (cmd.out_load_press || cmd.out_load_dab) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ev_cmd_r <= in_cmd;
      px_r     <= in_pointer_x;
      py_r     <= in_pointer_y;
      left_r   <= in_left_button;
      vis_r    <= in_layer_visible;
    end
    if (cmd.delta) begin
      dx_r <= DW'(px_r) - DW'(anchor_x_r);
      dy_r <= DW'(py_r) - DW'(anchor_y_r);
    end
    if (cmd.square) begin
      dxsq_r <= sdsg_pkg::SQ_W'(dx_r * dx_r);
      dysq_r <= sdsg_pkg::SQ_W'(dy_r * dy_r);
    end
    if (cmd.divn_save) begin
      n_r    <= div_q[NW-1:0];
      newc_r <= div_rem[SW-1:0];
    end
    if (cmd.dab_init) begin
      t_r <= TW'(sp) - TW'(carried_r);
    end else if (cmd.dab_next) begin
      t_r <= t_r + TW'(sp);
    end
    if (cmd.mul) begin
      prod_r <= PW'((cmd.axis_y ? dy_r : dx_r) * t_r);
    end
    if (cmd.off_clear) begin
      offx_r <= '0;
      offy_r <= '0;
    end else if (cmd.divo_save) begin
      if (cmd.axis_y) offy_r <= off_new;
      else offx_r <= off_new;
    end
    if (cmd.pos) begin
      posx_r <= sdsg_pkg::round_q8(ax_q8 + offx_r);
      posy_r <= sdsg_pkg::round_q8(ay_q8 + offy_r);
    end
    if (cmd.out_load_press) begin
      out_x_r     <= px_r;
      out_y_r     <= py_r;
      out_last_r  <= 1'b1;
      out_trunc_r <= 1'b0;
    end else if (cmd.out_load_dab) begin
      out_x_r     <= posx_r;
      out_y_r     <= posy_r;
      out_last_r  <= k_r == m;
      out_trunc_r <= (k_r == m) && over;
    end
  end

  always_comb begin
    stat.ev_cmd    = ev_cmd_r;
    stat.left      = left_r;
    stat.vis       = vis_r;
    stat.drag      = drag_r;
    stat.sqrt_busy = sqrt_busy;
    stat.div_busy  = div_busy;
    stat.n_zero    = n_r == '0;
    stat.len_zero  = len == '0;
    stat.last      = k_r == m;
    stat.out_free  = out_free;
  end

  assign out_valid     = out_valid_r;
  assign out_dab_x     = out_x_r;
  assign out_dab_y     = out_y_r;
  assign out_last_dab  = out_last_r;
  assign out_truncated = out_trunc_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sqrt_busy && div_busy))
    else $error("sqrt and divider active together");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load_press || cmd.out_load_dab) |-> out_free)
    else $error("output register overwritten");

  a_carry_below_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (carried_r < sdsg_pkg::CARRY_W'($past(sp))))
    else $error("carried distance not below spacing");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load_dab |-> (k_r != '0 && k_r <= KW'(MAX_DABS)))
    else $error("dab index out of range");

endmodule

FILE: rtl/sdsg_ctrl.sv
module sdsg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sdsg_pkg::sdsg_stat_t stat,
  output sdsg_pkg::sdsg_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_PRESS, S_SQUARE, S_SQRT_GO, S_SQRT_WAIT,
    S_DIVN_GO, S_DIVN_WAIT, S_NCHECK, S_MULX, S_DIVX_GO, S_DIVX_WAIT,
    S_MULY, S_DIVY_GO, S_DIVY_WAIT, S_POS, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.delta = 1'b1;
        priority if (stat.ev_cmd == sdsg_pkg::CMD_PRESS && stat.left && stat.vis) begin
          state_nxt = S_PRESS;
        end else if (stat.ev_cmd == sdsg_pkg::CMD_RELEASE && stat.left) begin
          cmd.release_drag = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.ev_cmd == sdsg_pkg::CMD_MOVE && stat.drag && stat.vis) begin
          state_nxt = S_SQUARE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PRESS: begin
        if (stat.out_free) begin
          cmd.press = 1'b1;
          cmd.out_load_press = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt = S_SQRT_GO;
      end
      S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!stat.sqrt_busy) state_nxt = S_DIVN_GO;
      end
      S_DIVN_GO: begin
        cmd.divn_start = 1'b1;
        state_nxt = S_DIVN_WAIT;
      end
      S_DIVN_WAIT: begin
        if (!stat.div_busy) begin
          cmd.divn_save = 1'b1;
          cmd.dab_init = 1'b1;
          state_nxt = S_NCHECK;
        end
      end
      S_NCHECK: begin
        if (stat.n_zero) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        if (stat.len_zero) begin
          cmd.off_clear = 1'b1;
          state_nxt = S_POS;
        end else begin
          cmd.mul = 1'b1;
          state_nxt = S_DIVX_GO;
        end
      end
      S_DIVX_GO: begin
        cmd.divo_start = 1'b1;
        state_nxt = S_DIVX_WAIT;
      end
      S_DIVX_WAIT: begin
        if (!stat.div_busy) begin
          cmd.divo_save = 1'b1;
          state_nxt = S_MULY;
        end
      end
      S_MULY: begin
        cmd.axis_y = 1'b1;
        cmd.mul = 1'b1;
        state_nxt = S_DIVY_GO;
      end
      S_DIVY_GO: begin
        cmd.axis_y = 1'b1;
        cmd.divo_start = 1'b1;
        state_nxt = S_DIVY_WAIT;
      end
      S_DIVY_WAIT: begin
        cmd.axis_y = 1'b1;
        if (!stat.div_busy) begin
          cmd.divo_save = 1'b1;
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        cmd.pos = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load_dab = 1'b1;
          if (stat.last) begin
            cmd.commit = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.dab_next = 1'b1;
            state_nxt = S_MULX;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  a_save_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.divo_save |-> !stat.div_busy)
    else $error("offset saved while divider busy");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECODE)
    else $error("accepted request not decoded");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_IDLE)
    else $error("commit without return to idle");

endmodule

FILE: rtl/stroke_dab_spacing_generator_top.sv
// channel   direction  handshake               payload
// in_*      input      in_valid / in_ready     cmd, pointer_x, pointer_y, left_button,
//                                              layer_visible
// out_*     output     out_valid / out_ready   dab_x, dab_y, last_dab, truncated
// cfg_*     input      apb, cfg_pready tied 1  dab_spacing at byte address 0
//
// one request at a time; release and ignored requests return to idle from decode, a press after loading its output
// a move runs the sqrt unit (25 steps), then the serial divider (50 steps)
// for the dab count, then for each dab two 50-step
// divisions for the x and y offsets on the shared divider
// rst_n is synchronous, active low; spacing resets to 1, no drag in progress
// a stalled out_ready holds the dab in the output register; the sequencer
// waits only when the next output (a dab or a press) is ready to load

module stroke_dab_spacing_generator_top #(
  parameter int MAX_DABS = sdsg_pkg::MAX_DABS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sdsg_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [sdsg_pkg::COORD_W-1:0]  in_pointer_x,
  input  logic signed [sdsg_pkg::COORD_W-1:0]  in_pointer_y,
  input  logic                                 in_left_button,
  input  logic                                 in_layer_visible,
  // dab channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sdsg_pkg::COORD_W-1:0]  out_dab_x,
  output logic signed [sdsg_pkg::COORD_W-1:0]  out_dab_y,
  output logic                                 out_last_dab,
  output logic                                 out_truncated,
  // configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [sdsg_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [sdsg_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [sdsg_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  logic [sdsg_pkg::SPACING_W-1:0] spacing_r;
  logic                           cfg_wr;
  logic                           in_accept;
  sdsg_pkg::sdsg_cmd_t            cmd;
  sdsg_pkg::sdsg_stat_t           stat;

  // register write in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr == sdsg_pkg::ADDR_DAB_SPACING);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= sdsg_pkg::SPACING_W'(1);
    end else if (cfg_wr) begin
      spacing_r <= cfg_pwdata[sdsg_pkg::SPACING_W-1:0];
    end
  end

  // raw value reads back; zero acts as one inside the datapath
  assign cfg_prdata = (cfg_paddr == sdsg_pkg::ADDR_DAB_SPACING) ?
                      sdsg_pkg::CFG_DATA_W'(spacing_r) : '0;

  assign in_accept = in_valid && in_ready;

  // sequencer: decodes the request and steps the shared units
  sdsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: stroke state, sqrt, divider, offset and rounding, output register
  sdsg_dp #(.MAX_DABS(MAX_DABS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_accept        (in_accept),
    .in_cmd           (in_cmd),
    .in_pointer_x     (in_pointer_x),
    .in_pointer_y     (in_pointer_y),
    .in_left_button   (in_left_button),
    .in_layer_visible (in_layer_visible),
    .dab_spacing      (spacing_r),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_dab_x        (out_dab_x),
    .out_dab_y        (out_dab_y),
    .out_last_dab     (out_last_dab),
    .out_truncated    (out_truncated)
  );

endmodule
